// ===== hw/rtl/ttgr_pkg.sv =====
// Shared types and constants of the tap gesture recogniser.
// Used by ttgr_cfg_regs, ttgr_core and touch_tap_gesture_recognizer_unit.
// No dependencies.
package ttgr_pkg;

  // Default timestamp width in bits.
  localparam int unsigned TimeBitsDef = 48;

  // Width of the timing registers.
  localparam int unsigned CfgTimeW = 24;

  // Configuration port geometry.
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = CfgTimeW;

  // Width of the result stream data.
  localparam int unsigned OutDataW = 8;

  // Register indexes.
  localparam logic [CfgAddrW-1:0] RegDoubleTapEn  = 3'd0;
  localparam logic [CfgAddrW-1:0] RegDebounceTime = 3'd1;
  localparam logic [CfgAddrW-1:0] RegMinTapTime   = 3'd2;
  localparam logic [CfgAddrW-1:0] RegMaxTapTime   = 3'd3;
  localparam logic [CfgAddrW-1:0] RegDoubleWindow = 3'd4;

  // Reset values of the timing registers.
  localparam logic [CfgTimeW-1:0] DebounceTimeRst   = 24'd50000;
  localparam logic [CfgTimeW-1:0] MinTapTimeRst     = 24'd50000;
  localparam logic [CfgTimeW-1:0] MaxTapTimeRst     = 24'd1000000;
  localparam logic [CfgTimeW-1:0] DoubleWindowRst   = 24'd400000;

  // Gesture codes.
  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_SINGLE = 2'd1,
    GEST_DOUBLE = 2'd2
  } gesture_e;

  // Configuration as seen by the recogniser core.
  typedef struct packed {
    logic                double_tap_enable;
    logic [CfgTimeW-1:0] debounce_time;
    logic [CfgTimeW-1:0] min_tap_time;
    logic [CfgTimeW-1:0] max_tap_time;
    logic [CfgTimeW-1:0] double_window_time;
  } cfg_t;

endpackage

// ===== hw/rtl/touch_tap_gesture_recognizer_unit.sv =====
// Top level of the tap gesture recogniser: stream handshake, input register and
// result valid. Depends on ttgr_pkg, ttgr_cfg_regs and ttgr_core.
//
//  Channel  | Direction | Handshake                     | Payload
//  ---------+-----------+-------------------------------+----------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | touch_down, time_us, hold_idle
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | gesture
//  cfg      | in        | cfg_valid_i / cfg_ready_o     | register index, write data
//
// One poll request is accepted every cycle unless the result is stalled; each gives
// exactly one result request. A request passes the input register and then the core's
// result register, where the debounce, tap-length and window compares are worked out
// in a single pass. Reset returns all registers but the input payload to their default
// values and the recogniser to idle; there is no clearing pass, so requests are
// accepted from the first cycle after reset. A stalled result holds its value; the
// input register still takes a request in the same cycle the pending result is taken.
module touch_tap_gesture_recognizer_unit
  import ttgr_pkg::*;
#(
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Poll requests.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [0] touch_down, [TIME_BITS:1] time_us, [TIME_BITS+1] hold_idle, rest zero.
  input  logic [((TIME_BITS+9)/8)*8-1:0] s_axis_tdata,
  // Gesture results.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [1:0] gesture, rest zero.
  output logic [OutDataW-1:0] m_axis_tdata,
  // Configuration writes.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t                 cfg;
  gesture_e             gesture;
  logic                 step;
  logic                 in_accept;

  logic                 in_valid_d, in_valid_q;
  logic                 out_valid_d, out_valid_q;
  logic                 in_touch_q;
  logic [TIME_BITS-1:0] in_time_q;
  logic                 in_hold_q;

  // Configuration is always taken at once.
  assign cfg_ready_o = 1'b1;

  ttgr_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_addr_i (cfg_addr_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // The held request is processed whenever the result register is free or being
  // emptied in this cycle.
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = in_accept ? 1'b1 : (step ? 1'b0 : in_valid_q);
  assign out_valid_d = step ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_touch_q <= s_axis_tdata[0];
      in_time_q  <= s_axis_tdata[TIME_BITS:1];
      in_hold_q  <= s_axis_tdata[TIME_BITS+1];
    end
  end

  ttgr_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .touch_down_i (in_touch_q),
    .time_us_i    (in_time_q),
    .hold_idle_i  (in_hold_q),
    .cfg_i        (cfg),
    .gesture_o    (gesture)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-2){1'b0}}, gesture};

endmodule

// ===== hw/rtl/ttgr_cfg_regs.sv =====
// Configuration register file of the tap gesture recogniser.
// Depends on ttgr_pkg.
module ttgr_cfg_regs
  import ttgr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [CfgAddrW-1:0] wr_addr_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_d, cfg_q;

  // Writes to indexes beyond the register list are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_addr_i)
        RegDoubleTapEn:  cfg_d.double_tap_enable  = wr_data_i[0];
        RegDebounceTime: cfg_d.debounce_time      = wr_data_i;
        RegMinTapTime:   cfg_d.min_tap_time       = wr_data_i;
        RegMaxTapTime:   cfg_d.max_tap_time       = wr_data_i;
        RegDoubleWindow: cfg_d.double_window_time = wr_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.double_tap_enable  <= 1'b1;
      cfg_q.debounce_time      <= DebounceTimeRst;
      cfg_q.min_tap_time       <= MinTapTimeRst;
      cfg_q.max_tap_time       <= MaxTapTimeRst;
      cfg_q.double_window_time <= DoubleWindowRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/ttgr_core.sv =====
// Tap recogniser core: gesture state, edge debounce and the result register.
// Depends on ttgr_pkg.
module ttgr_core
  import ttgr_pkg::*;
#(
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 touch_down_i,
  input  logic [TIME_BITS-1:0] time_us_i,
  input  logic                 hold_idle_i,
  input  cfg_t                 cfg_i,
  output gesture_e             gesture_o
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_WAIT    = 2'd2
  } phase_e;

  localparam int unsigned PadW = TIME_BITS - CfgTimeW;

  phase_e               phase_d, phase_q;
  logic                 level_d, level_q;
  logic                 pend_d, pend_q;
  logic [TIME_BITS-1:0] press_time_d, press_time_q;
  logic [TIME_BITS-1:0] release_time_d, release_time_q;
  logic [TIME_BITS-1:0] first_rel_d, first_rel_q;
  gesture_e             gesture_d, gesture_q;

  // Elapsed times wrap modulo the timestamp width.
  logic [TIME_BITS-1:0] since_press, since_release, since_first;
  logic [TIME_BITS-1:0] debounce_w, min_tap_w, max_tap_w, window_w;
  logic                 debounce_ok, tap_len_ok, in_window;

  assign since_press   = time_us_i - press_time_q;
  assign since_release = time_us_i - release_time_q;
  assign since_first   = time_us_i - first_rel_q;

  assign debounce_w = {{PadW{1'b0}}, cfg_i.debounce_time};
  assign min_tap_w  = {{PadW{1'b0}}, cfg_i.min_tap_time};
  assign max_tap_w  = {{PadW{1'b0}}, cfg_i.max_tap_time};
  assign window_w   = {{PadW{1'b0}}, cfg_i.double_window_time};

  assign debounce_ok = (since_press >= debounce_w) && (since_release >= debounce_w);
  assign tap_len_ok  = (since_press >= min_tap_w) && (since_press <= max_tap_w);
  assign in_window   = (since_first <= window_w);

  always_comb begin
    phase_d        = phase_q;
    level_d        = level_q;
    pend_d         = pend_q;
    press_time_d   = press_time_q;
    release_time_d = release_time_q;
    first_rel_d    = first_rel_q;
    gesture_d      = GEST_NONE;

    if (hold_idle_i) begin
      phase_d = PH_IDLE;
      pend_d  = 1'b0;
      level_d = touch_down_i;
    end else if (touch_down_i != level_q) begin
      if (debounce_ok) begin
        level_d = touch_down_i;
        if (touch_down_i) begin
          press_time_d = time_us_i;
          phase_d      = PH_PRESSED;
        end else begin
          release_time_d = time_us_i;
          phase_d        = PH_IDLE;
          if (phase_q == PH_PRESSED) begin
            if (!tap_len_ok) begin
              pend_d = 1'b0;
            end else if (!pend_q) begin
              if (cfg_i.double_tap_enable) begin
                first_rel_d = time_us_i;
                pend_d      = 1'b1;
                phase_d     = PH_WAIT;
              end else begin
                gesture_d = GEST_SINGLE;
              end
            end else begin
              pend_d    = 1'b0;
              gesture_d = in_window ? GEST_DOUBLE : GEST_SINGLE;
            end
          end
        end
      end
    end else if (phase_q == PH_WAIT && pend_q && !in_window) begin
      // The second-tap window has run out.
      phase_d   = PH_IDLE;
      pend_d    = 1'b0;
      gesture_d = GEST_SINGLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      level_q        <= 1'b0;
      pend_q         <= 1'b0;
      press_time_q   <= '0;
      release_time_q <= '0;
      first_rel_q    <= '0;
      gesture_q      <= GEST_NONE;
    end else if (step_i) begin
      phase_q        <= phase_d;
      level_q        <= level_d;
      pend_q         <= pend_d;
      press_time_q   <= press_time_d;
      release_time_q <= release_time_d;
      first_rel_q    <= first_rel_d;
      gesture_q      <= gesture_d;
    end
  end

  assign gesture_o = gesture_q;

  // Waiting for a second tap always has a first tap pending.
  a_wait_has_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WAIT) |-> pend_q)
    else $error("waiting phase without a pending first tap");

  // A hold leaves the recogniser idle with nothing pending.
  a_hold_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && hold_idle_i) |=> (phase_q == PH_IDLE && !pend_q))
    else $error("hold did not clear the recogniser");

  // Any reported gesture resolves everything that was pending.
  a_gesture_resolves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && gesture_d != GEST_NONE) |=> (phase_q == PH_IDLE && !pend_q))
    else $error("gesture reported but recogniser not idle");

  // A double tap needs a first tap pending beforehand.
  a_double_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && gesture_d == GEST_DOUBLE) |-> pend_q)
    else $error("double tap without a pending first tap");

endmodule
